// File: design/tlc_pkg.sv
// Shared types, codes and default sizes of the TTL lookup cache.
package tlc_pkg;

	localparam int TLC_ENTRIES   = 64;
	localparam int TLC_KEY_BITS  = 64;
	localparam int TLC_TIME_BITS = 48;

	localparam logic [31:0] TLC_TTL_RESET = 32'd60000;
	localparam logic [6:0]  TLC_PURGE_MAX = 7'd127;

	typedef enum logic [1:0] {
		ACT_LOOKUP = 2'd0,
		ACT_SET    = 2'd1,
		ACT_READ   = 2'd2,
		ACT_SWEEP  = 2'd3
	} tlc_action_t;

	typedef enum logic [2:0] {
		STS_MISS      = 3'd0,
		STS_PENDING   = 3'd1,
		STS_READY     = 3'd2,
		STS_NOT_FOUND = 3'd3,
		STS_FULL      = 3'd4,
		STS_DONE      = 3'd5
	} tlc_status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_WAIT,
		ST_DECIDE
	} tlc_state_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] key;
		logic [47:0] now_ms;
		logic [31:0] response_handle;
	} tlc_req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [31:0] handle_out;
		logic [6:0]  purged_count;
	} tlc_rsp_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic wipe;
		logic finish;
	} tlc_cmd_t;

	typedef struct packed {
		logic last;
	} tlc_sts_t;

endpackage

// File: design/tlc_ctrl.sv
// Controller state machine that sequences clearing, table scans and result words.
module tlc_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  tlc_pkg::tlc_sts_t sts,
	output tlc_pkg::tlc_cmd_t cmd,
	output logic            busy
);
	import tlc_pkg::*;

	tlc_state_t state_q;
	tlc_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		busy    = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.wipe = 1'b1;
				if (sts.last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.last) begin
					state_d = ST_WAIT;
				end
			end
			ST_WAIT: begin
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.finish = 1'b1;
				state_d    = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

endmodule

// File: design/tlc_dp.sv
// Datapath with the entry memory, scan counter, match tracking and result register.
module tlc_dp #(
	parameter int ENTRIES   = tlc_pkg::TLC_ENTRIES,
	parameter int KEY_BITS  = tlc_pkg::TLC_KEY_BITS,
	parameter int TIME_BITS = tlc_pkg::TLC_TIME_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tlc_pkg::tlc_cmd_t cmd,
	output tlc_pkg::tlc_sts_t sts,
	input  tlc_pkg::tlc_req_t req,
	input  logic              cfg_wr,
	input  logic [31:0]       cfg_data,
	output logic              done,
	output tlc_pkg::tlc_rsp_t rsp
);
	import tlc_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);
	localparam int SUM_W = ((TIME_BITS > 32) ? TIME_BITS : 32) + 1;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	logic                 mem_valid  [ENTRIES];
	logic [KEY_BITS-1:0]  mem_key    [ENTRIES];
	logic                 mem_ready  [ENTRIES];
	logic [TIME_BITS-1:0] mem_exp    [ENTRIES];
	logic [31:0]          mem_handle [ENTRIES];

	logic [31:0]          ttl_q;
	tlc_action_t          action_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [TIME_BITS-1:0] now_q;
	logic [31:0]          handle_q;
	logic [IDX_W-1:0]     cnt_q;
	logic                 last;

	logic                 rd_vld_s1;
	logic [IDX_W-1:0]     rd_idx_s1;
	logic                 rd_valid_s1;
	logic [KEY_BITS-1:0]  rd_key_s1;
	logic                 rd_ready_s1;
	logic [TIME_BITS-1:0] rd_exp_s1;
	logic [31:0]          rd_handle_s1;

	logic                 hit_q;
	logic [IDX_W-1:0]     hit_idx_q;
	logic                 hit_ready_q;
	logic                 hit_expired_q;
	logic [31:0]          hit_handle_q;
	logic                 free_q;
	logic [IDX_W-1:0]     free_idx_q;
	logic [6:0]           purged_q;

	logic                 rd_match;
	logic                 rd_expired;
	logic                 evict;
	logic [SUM_W-1:0]     exp_sum;
	logic [TIME_BITS-1:0] exp_new;

	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic                 wr_valid;
	logic [KEY_BITS-1:0]  wr_key;
	logic                 wr_ready;
	logic [TIME_BITS-1:0] wr_exp;
	logic [31:0]          wr_handle;
	logic [2:0]           res_status;
	logic [31:0]          res_handle;

	assign last     = (cnt_q == IDX_W'(ENTRIES - 1));
	assign sts.last = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_q <= TLC_TTL_RESET;
		end else if (cfg_wr && (cfg_data != 32'd0)) begin
			ttl_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= tlc_action_t'(req.action);
			key_q    <= KEY_BITS'(req.key);
			now_q    <= TIME_BITS'(req.now_ms);
			handle_q <= req.response_handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.scan || cmd.wipe) begin
			cnt_q <= last ? '0 : cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			rd_idx_s1    <= cnt_q;
			rd_valid_s1  <= mem_valid[cnt_q];
			rd_key_s1    <= mem_key[cnt_q];
			rd_ready_s1  <= mem_ready[cnt_q];
			rd_exp_s1    <= mem_exp[cnt_q];
			rd_handle_s1 <= mem_handle[cnt_q];
		end
	end

	assign rd_match   = rd_vld_s1 && rd_valid_s1 && (rd_key_s1 == key_q);
	assign rd_expired = (rd_exp_s1 <= now_q);
	assign evict      = rd_vld_s1 && (action_q == ACT_SWEEP) && rd_valid_s1 && rd_expired;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			purged_q <= '0;
		end else if (cmd.load) begin
			hit_q    <= 1'b0;
			free_q   <= 1'b0;
			purged_q <= '0;
		end else begin
			if (rd_match && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (rd_vld_s1 && !rd_valid_s1 && !free_q) begin
				free_q <= 1'b1;
			end
			if (evict && (purged_q != TLC_PURGE_MAX)) begin
				purged_q <= purged_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_match && !hit_q) begin
			hit_idx_q     <= rd_idx_s1;
			hit_ready_q   <= rd_ready_s1;
			hit_expired_q <= rd_expired;
			hit_handle_q  <= rd_handle_s1;
		end
		if (rd_vld_s1 && !rd_valid_s1 && !free_q) begin
			free_idx_q <= rd_idx_s1;
		end
	end

	assign exp_sum = SUM_W'(now_q) + SUM_W'(ttl_q);
	assign exp_new = (exp_sum >= SUM_W'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(exp_sum);

	always_comb begin
		wr_en      = cmd.wipe;
		wr_addr    = cnt_q;
		wr_valid   = 1'b0;
		wr_key     = '0;
		wr_ready   = 1'b0;
		wr_exp     = '0;
		wr_handle  = '0;
		res_status = STS_DONE;
		res_handle = '0;
		if (evict) begin
			wr_en     = 1'b1;
			wr_addr   = rd_idx_s1;
			wr_key    = rd_key_s1;
			wr_ready  = rd_ready_s1;
			wr_exp    = rd_exp_s1;
			wr_handle = rd_handle_s1;
		end
		if (cmd.finish) begin
			wr_valid = 1'b1;
			wr_key   = key_q;
			wr_exp   = exp_new;
			case (action_q)
				ACT_LOOKUP: begin
					if (hit_q) begin
						if (hit_ready_q && hit_expired_q) begin
							wr_en      = 1'b1;
							wr_addr    = hit_idx_q;
							res_status = STS_MISS;
						end else if (hit_ready_q) begin
							res_status = STS_READY;
						end else begin
							res_status = STS_PENDING;
						end
					end else if (free_q) begin
						wr_en      = 1'b1;
						wr_addr    = free_idx_q;
						res_status = STS_MISS;
					end else begin
						res_status = STS_FULL;
					end
				end
				ACT_SET: begin
					wr_ready  = 1'b1;
					wr_handle = handle_q;
					if (hit_q || free_q) begin
						wr_en      = 1'b1;
						wr_addr    = hit_q ? hit_idx_q : free_idx_q;
						res_status = STS_DONE;
					end else begin
						res_status = STS_FULL;
					end
				end
				ACT_READ: begin
					if (hit_q && hit_ready_q) begin
						res_status = STS_READY;
						res_handle = hit_handle_q;
					end else begin
						res_status = STS_NOT_FOUND;
					end
				end
				default: begin
					res_status = STS_DONE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_valid[wr_addr]  <= wr_valid;
			mem_key[wr_addr]    <= wr_key;
			mem_ready[wr_addr]  <= wr_ready;
			mem_exp[wr_addr]    <= wr_exp;
			mem_handle[wr_addr] <= wr_handle;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.finish;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			rsp.status       <= res_status;
			rsp.handle_out   <= res_handle;
			rsp.purged_count <= (action_q == ACT_SWEEP) ? purged_q : 7'd0;
		end
	end

endmodule

// File: design/ttl_lookup_cache_with_pending_unit.sv
// Top level of the TTL lookup cache with pending entries.
//
// A request word is taken at a rising edge where start is high and busy is low.
// Every request gives exactly one result word on rsp, shown for one cycle with
// done high; the receiver takes it then and cannot hold it off.
// Each request scans the whole table, one entry per cycle from the entry
// memory's read port, so busy stays high from the accepting edge until done
// rises. A new request can be taken in the cycle where done is high. Sweeps
// erase expired entries through the same scan.
// After reset the block clears every entry's valid bit, one entry per cycle,
// and holds busy high until the last entry is cleared. The lifetime register
// resets to 60000 ms; cfg_ready is always high and a write of zero is ignored.
// The lifetime should only be written while no request is in flight.
module ttl_lookup_cache_with_pending_unit #(
	parameter int ENTRIES   = tlc_pkg::TLC_ENTRIES,
	parameter int KEY_BITS  = tlc_pkg::TLC_KEY_BITS,
	parameter int TIME_BITS = tlc_pkg::TLC_TIME_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tlc_pkg::tlc_req_t req,
	output logic              done,
	output tlc_pkg::tlc_rsp_t rsp,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [31:0]       cfg_data
);
	import tlc_pkg::*;

	tlc_cmd_t cmd;
	tlc_sts_t sts;
	logic     ctrl_busy;

	assign cfg_ready = 1'b1;
	assign busy      = ctrl_busy;

	tlc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (ctrl_busy)
	);

	tlc_dp #(
		.ENTRIES   (ENTRIES),
		.KEY_BITS  (KEY_BITS),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req      (req),
		.cfg_wr   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.done     (done),
		.rsp      (rsp)
	);

endmodule
